// ===== hdl/evs_pkg.sv =====
// Shared types and constants of the elastic velocity stencil update block.
// No dependencies; compiled first.
`default_nettype none

package evs_pkg;

	// Field and stencil sizes
	localparam int W          = 32;
	localparam int TAP_W      = 2;
	localparam int MAX_TAPS   = 4;
	localparam int DATA_WIDTH = 32;

	// Configuration register map
	localparam int NUM_REGS  = 8;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS1_TAP0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS0_TAP0 = 3'd4;

	// Shared multiplier operand selection
	typedef enum logic [1:0] {
		MUL_AXIS1 = 2'd0,  // slow-axis coefficient times slow-axis difference
		MUL_AXIS0 = 2'd1,  // fast-axis coefficient times fast-axis difference
		MUL_SUMLO = 2'd2,  // buoyancy times low word of tap sum (unsigned)
		MUL_SUMHI = 2'd3   // buoyancy times high word of tap sum (signed)
	} mul_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     hold_en;
		logic     acc_en;
		logic     scale_en;
		logic     out_en;
	} evs_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic last;
		logic out_busy;
	} evs_sts_t;

endpackage

`default_nettype wire

// ===== hdl/evs_in_if.sv =====
// Input channel of the velocity update: one item per stencil tap.
// Depends on evs_pkg for field widths.
`default_nettype none

interface evs_in_if
	import evs_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic [TAP_W-1:0]       tap;
	logic signed [W-1:0]    stress_a_fwd;
	logic signed [W-1:0]    stress_a_back;
	logic signed [W-1:0]    stress_b_fwd;
	logic signed [W-1:0]    stress_b_back;
	logic signed [W-1:0]    buoy_00;
	logic signed [W-1:0]    buoy_01;
	logic signed [W-1:0]    buoy_10;
	logic signed [W-1:0]    buoy_11;
	logic signed [W-1:0]    vel_old;
	logic                   last_tap;

	modport source (
		output valid, func, tap, stress_a_fwd, stress_a_back, stress_b_fwd, stress_b_back,
		output buoy_00, buoy_01, buoy_10, buoy_11, vel_old, last_tap,
		input  ready
	);
	modport sink (
		input  valid, func, tap, stress_a_fwd, stress_a_back, stress_b_fwd, stress_b_back,
		input  buoy_00, buoy_01, buoy_10, buoy_11, vel_old, last_tap,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/evs_out_if.sv =====
// Output channel of the velocity update: one item per finished point.
// Depends on evs_pkg for field widths.
`default_nettype none

interface evs_out_if
	import evs_pkg::*;
;
	logic                valid;
	logic                ready;
	logic signed [W-1:0] vel_new;
	logic                component;

	modport source (output valid, vel_new, component, input ready);
	modport sink (input valid, vel_new, component, output ready);
endinterface

`default_nettype wire

// ===== hdl/evs_datapath.sv =====
// Datapath: coefficient registers, shared 32x33 multiplier, tap accumulator,
// buoyancy scaling and the output register. Depends on evs_pkg.
`default_nettype none

module evs_datapath
	import evs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [W-1:0]         cfg_data,
	input  wire evs_cmd_t             cmd,
	output evs_sts_t                  sts,
	evs_in_if.sink                    in_ch,
	evs_out_if.source                 out_ch
);

	localparam int PW = 2 * W + 1;    // product width of 32 x 33
	localparam int TW = PW - 16;      // floored tap term width
	localparam int FW = PW + W;       // full scale product width
	localparam int SW = 42;           // clamped scale, +-2^40
	localparam int VW = SW + 1;       // update sum width

	localparam logic signed [FW-17:0] SCALE_LIM = (FW-16)'(64'sd1 <<< 40);
	localparam logic signed [VW-1:0]  VMAX = VW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [VW-1:0]  VMIN = -VMAX - VW'(1);

	// Coefficient registers
	logic signed [W-1:0] coef1_q [MAX_TAPS];
	logic signed [W-1:0] coef0_q [MAX_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				coef1_q[i] <= '0;
				coef0_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index >= REG_AXIS0_TAP0) begin
				coef0_q[TAP_W'(cfg_index - REG_AXIS0_TAP0)] <= cfg_data;
			end else begin
				coef1_q[TAP_W'(cfg_index - REG_AXIS1_TAP0)] <= cfg_data;
			end
		end
	end

	// Item capture: differences and buoyancy are formed on the way in
	logic signed [W:0]     da_q, db_q;
	logic [TAP_W-1:0]      tap_q;
	logic                  func_q, last_q;
	logic signed [W-1:0]   vel_q, b_q;
	logic signed [W+1:0]   buoy_sum;
	logic signed [W+1:0]   buoy_avg;

	assign buoy_sum = (W+2)'(in_ch.buoy_00) + (W+2)'(in_ch.buoy_01)
	                + (W+2)'(in_ch.buoy_10) + (W+2)'(in_ch.buoy_11);
	// times 0.25, floored
	assign buoy_avg = buoy_sum >>> 2;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			da_q   <= (W+1)'(in_ch.stress_a_fwd) - (W+1)'(in_ch.stress_a_back);
			db_q   <= (W+1)'(in_ch.stress_b_fwd) - (W+1)'(in_ch.stress_b_back);
			tap_q  <= in_ch.tap;
			func_q <= in_ch.func;
			vel_q  <= in_ch.vel_old;
			b_q    <= in_ch.func ? W'(buoy_avg) : in_ch.buoy_00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (cmd.load_in) begin
			last_q <= in_ch.last_tap;
		end
	end

	// Shared multiplier
	logic signed [W-1:0] mul_a;
	logic signed [W:0]   mul_d;
	logic signed [PW-1:0] mul_p;
	logic signed [PW-1:0] p_q, hold_q;
	logic signed [63:0]   tsum_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_AXIS1: begin
				mul_a = coef1_q[tap_q];
				mul_d = da_q;
			end
			MUL_AXIS0: begin
				mul_a = coef0_q[tap_q];
				mul_d = db_q;
			end
			MUL_SUMLO: begin
				mul_a = b_q;
				mul_d = {1'b0, tsum_q[31:0]};
			end
			MUL_SUMHI: begin
				mul_a = b_q;
				mul_d = {tsum_q[63], tsum_q[63:32]};
			end
			default: begin
				mul_a = '0;
				mul_d = '0;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_d);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) p_q <= mul_p;
		if (cmd.hold_en) hold_q <= p_q;
	end

	// Tap accumulation: both products floored, then one saturating add
	logic signed [TW:0] term;
	logic signed [64:0] acc_sum;
	logic               tap_ok;

	assign term    = (TW+1)'(hold_q >>> 16) + (TW+1)'(p_q >>> 16);
	assign acc_sum = 65'(tsum_q) + 65'(term);
	assign tap_ok  = {1'b0, tap_q} < (TAP_W+1)'(MAX_TAPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsum_q <= '0;
		end else if (cmd.out_en) begin
			tsum_q <= '0;
		end else if (cmd.acc_en && tap_ok) begin
			if (acc_sum[64] != acc_sum[63]) begin
				tsum_q <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			end else begin
				tsum_q <= acc_sum[63:0];
			end
		end
	end

	// Buoyancy scaling: high partial in p_q, low partial in hold_q
	logic signed [FW-1:0]  full_p;
	logic signed [FW-17:0] full_fl;
	logic signed [SW-1:0]  scaled_q;

	assign full_p  = (FW'(p_q) <<< 32) + FW'(hold_q);
	assign full_fl = (FW-16)'(full_p >>> 16);

	always_ff @(posedge clk) begin
		if (cmd.scale_en) begin
			if (full_fl > SCALE_LIM) begin
				scaled_q <= SW'(SCALE_LIM);
			end else if (full_fl < -SCALE_LIM) begin
				scaled_q <= SW'(-SCALE_LIM);
			end else begin
				scaled_q <= SW'(full_fl);
			end
		end
	end

	// Update sum and output register
	logic signed [VW-1:0] total;
	logic signed [VW-1:0] total_sat;
	logic                 out_valid_q;
	logic signed [W-1:0]  out_vel_q;
	logic                 out_comp_q;

	assign total = VW'(scaled_q) + VW'(vel_q);

	always_comb begin
		if (total > VMAX) total_sat = VMAX;
		else if (total < VMIN) total_sat = VMIN;
		else total_sat = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_en) begin
			out_vel_q  <= W'(total_sat);
			out_comp_q <= func_q;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.vel_new   = out_vel_q;
	assign out_ch.component = out_comp_q;

	assign sts.last     = last_q;
	assign sts.out_busy = out_valid_q && !out_ch.ready;

	// A finished point always leaves the accumulator clear
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_en |=> tsum_q == '0)
		else $error("tap sum not cleared after result");

endmodule

`default_nettype wire

// ===== hdl/evs_ctrl.sv =====
// Controller: sequences capture, the two tap products, accumulation and
// the three-step buoyancy scaling. Depends on evs_pkg.
`default_nettype none

module evs_ctrl
	import evs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire evs_sts_t sts,
	output evs_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_ACC,
		S_SC_LO,
		S_SC_HI,
		S_SC_SUM,
		S_SC_OUT
	} state_t;

	state_t state_q;
	logic   accept;

	// Next item may be captured while a non-final tap accumulates
	assign in_ready = (state_q == S_IDLE) || (state_q == S_ACC && !sts.last);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (accept) state_q <= S_MUL_A;
				S_MUL_A:  state_q <= S_MUL_B;
				S_MUL_B:  state_q <= S_ACC;
				S_ACC: begin
					if (sts.last) state_q <= S_SC_LO;
					else if (accept) state_q <= S_MUL_A;
					else state_q <= S_IDLE;
				end
				S_SC_LO:  state_q <= S_SC_HI;
				S_SC_HI:  state_q <= S_SC_SUM;
				S_SC_SUM: state_q <= S_SC_OUT;
				S_SC_OUT: if (!sts.out_busy) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_AXIS1;
		cmd.load_in  = accept;
		case (state_q)
			S_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AXIS1;
			end
			S_MUL_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AXIS0;
				cmd.hold_en = 1'b1;
			end
			S_ACC:    cmd.acc_en = 1'b1;
			S_SC_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SUMLO;
			end
			S_SC_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SUMHI;
				cmd.hold_en = 1'b1;
			end
			S_SC_SUM: cmd.scale_en = 1'b1;
			S_SC_OUT: cmd.out_en = !sts.out_busy;
			default:  ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/elastic_velocity_stencil_update.sv =====
// Top level of the elastic velocity stencil update block.
// Depends on evs_pkg, evs_in_if, evs_out_if, evs_ctrl and evs_datapath.
//
// Usage:
//   in_ch takes one item per stencil tap of a velocity point; the item with
//   last_tap set closes the point and yields one item on out_ch (vel_new and
//   component). Coefficients are written through cfg_we/cfg_index/cfg_data,
//   index 0..3 slow-axis taps, 4..7 fast-axis taps; the user must write them
//   only while idle, which the block does not enforce. One 32x33 multiplier
//   is shared by the two tap products and the two partial products of the
//   buoyancy scaling. A tap runs both products, then the accumulate, which
//   overlaps the next capture; a final tap then runs both partials, the scaling
//   sum and the output write; the next item is accepted the cycle after it.
// Reset: arst_n clears coefficients, the tap accumulator and all valid state.
// Stall: the output register holds one result; while it waits, further
//   non-final taps are still accepted, and a new final result waits in the
//   controller until out_ch.ready frees the register.
`default_nettype none

module elastic_velocity_stencil_update
	import evs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [W-1:0]         cfg_data,
	evs_in_if.sink                    in_ch,
	evs_out_if.source                 out_ch
);

	evs_cmd_t cmd;
	evs_sts_t sts;

	evs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	evs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// A final tap blocks further items until its result is out
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.last_tap) |=> !in_ch.ready)
		else $error("item accepted right after a final tap");

	// With the output free, a final tap's result appears on out_ch
	a_last_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.last_tap && !out_ch.valid)
			|-> ##8 out_ch.valid)
		else $error("result missing after final tap");

	// No result appears unless a final tap was taken
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(!in_ch.ready))
		else $error("result without pending point");

endmodule

`default_nettype wire

// ===== dv/evs_velocity_checker.sv =====
// Checker for the elastic velocity stencil update: watches the coefficient port and
// both channels, predicts each updated velocity and compares it with the block's output.
// Depends on evs_pkg, evs_in_if and evs_out_if.
`default_nettype none

module evs_velocity_checker
	import evs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [W-1:0]         cfg_data,
	evs_in_if                         in_ch,
	evs_out_if                        out_ch,
	output int                        errors,
	output int                        pending
);

	// Accumulator and update limits
	localparam logic signed [64:0]  ACC_HI  = 65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0]  ACC_LO  = -ACC_HI - 65'sd1;
	localparam logic signed [127:0] UPD_LIM = 128'sh100_0000_0000;
	localparam logic signed [127:0] VEL_HI  = (128'sd1 <<< (DATA_WIDTH - 1)) - 128'sd1;
	localparam logic signed [127:0] VEL_LO  = -VEL_HI - 128'sd1;

	typedef struct packed {
		logic signed [W-1:0] vel;
		logic                comp;
	} vel_result_t;

	logic signed [W-1:0] coef_slow [MAX_TAPS];
	logic signed [W-1:0] coef_fast [MAX_TAPS];
	logic signed [63:0]  tap_acc;
	vel_result_t         vel_expected [$];
	vel_result_t         want;
	logic signed [64:0]  acc_next;

	// Weighted stress differences of one tap, each product floored to Q16.16
	function automatic logic signed [63:0] tap_term(input logic [TAP_W-1:0] tp,
			input logic signed [W-1:0] af, ab, bf, bb);
		logic signed [W:0]   da, db;
		logic signed [2*W:0] pa, pb;
		da = af - ab;
		db = bf - bb;
		pa = coef_slow[tp] * da;
		pb = coef_fast[tp] * db;
		return (pa >>> 16) + (pb >>> 16);
	endfunction

	// Close a point: scale the tap sum by the buoyancy and add the old velocity
	function automatic vel_result_t velocity_update(input logic fn,
			input logic signed [W-1:0] b00, b01, b10, b11, vold);
		logic signed [W+1:0] b4;
		logic signed [W+1:0] buoy;
		logic signed [127:0] upd;
		logic signed [127:0] tot;
		vel_result_t         r;
		b4   = b00 + b01 + b10 + b11;
		buoy = fn ? (b4 >>> 2) : b00;
		upd  = tap_acc * buoy;
		upd  = upd >>> 16;
		if (upd > UPD_LIM)
			upd = UPD_LIM;
		if (upd < -UPD_LIM)
			upd = -UPD_LIM;
		tot = upd + vold;
		if (tot > VEL_HI)
			tot = VEL_HI;
		if (tot < VEL_LO)
			tot = VEL_LO;
		r.vel  = tot[W-1:0];
		r.comp = fn;
		return r;
	endfunction

	// Output items are checked before new tap items are predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				coef_slow[i] = '0;
				coef_fast[i] = '0;
			end
			tap_acc = '0;
			vel_expected.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index < REG_AXIS0_TAP0)
					coef_slow[TAP_W'(cfg_index - REG_AXIS1_TAP0)] = cfg_data;
				else
					coef_fast[TAP_W'(cfg_index - REG_AXIS0_TAP0)] = cfg_data;
			end

			if (out_ch.valid && out_ch.ready) begin
				if (vel_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, vel_new %h component %b", $time,
						out_ch.vel_new, out_ch.component);
				end else begin
					want = vel_expected.pop_front();
					if (out_ch.vel_new !== want.vel) begin
						errors++;
						$display("%0t: vel_new expected %h, actual %h", $time,
							want.vel, out_ch.vel_new);
					end
					if (out_ch.component !== want.comp) begin
						errors++;
						$display("%0t: component expected %b, actual %b", $time,
							want.comp, out_ch.component);
					end
				end
			end

			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.tap < MAX_TAPS) begin
					acc_next = tap_acc + tap_term(in_ch.tap, in_ch.stress_a_fwd,
						in_ch.stress_a_back, in_ch.stress_b_fwd, in_ch.stress_b_back);
					if (acc_next > ACC_HI)
						acc_next = ACC_HI;
					if (acc_next < ACC_LO)
						acc_next = ACC_LO;
					tap_acc = acc_next[63:0];
				end
				if (in_ch.last_tap) begin
					vel_expected.push_back(velocity_update(in_ch.func, in_ch.buoy_00,
						in_ch.buoy_01, in_ch.buoy_10, in_ch.buoy_11, in_ch.vel_old));
					tap_acc = '0;
				end
			end

			pending = vel_expected.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_elastic_velocity_stencil_update.sv =====
// Top of the velocity update testbench: clock, reset, coefficient writes and tap items.
// Depends on evs_pkg, evs_in_if, evs_out_if, the block and evs_velocity_checker.
`default_nettype none

module tb_elastic_velocity_stencil_update;
	import evs_pkg::*;

	localparam int IDLE_PCT      = 34;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS   = 130;
	localparam int BIG_ITEMS     = 40;

	localparam logic FUNC_VX = 1'b0;
	localparam logic FUNC_VZ = 1'b1;

	localparam logic signed [W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [W-1:0] Q_MIN  = 32'sh8000_0000;
	localparam logic signed [W-1:0] Q_ONE  = 32'sh0001_0000;
	localparam logic signed [W-1:0] Q_HALF = 32'sh0000_8000;
	localparam logic signed [W-1:0] Q_LSB  = 32'sh0000_0001;
	localparam logic signed [W-1:0] Q_NEG  = -32'sh0000_0001;

	typedef enum int {
		COEF_DIRECTED,
		COEF_ZERO,
		COEF_MAX,
		COEF_MIN,
		COEF_SMALL,
		COEF_FULL,
		COEF_MIX
	} coef_style_t;

	// Directed coefficients: unity, extremes, minus one, one half and one LSB
	localparam logic [W-1:0] DIRECTED_COEFS [NUM_REGS] = '{
		32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
		32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [W-1:0]         cfg_data  = '0;
	logic                 calm      = 1'b0;
	int                   errors;
	int                   pending;
	int                   items_sent = 0;

	evs_in_if  in_ch();
	evs_out_if out_ch();

	elastic_velocity_stencil_update i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	evs_velocity_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver stalls at random except during the calm stretch
	always @(negedge clk) begin
		out_ch.ready = calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Q16.16 value: extremes, zero, full random or within +-2.0
	function automatic logic signed [W-1:0] rand_q16();
		case ($urandom_range(9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3, 4, 5: return $urandom;
			default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	// Buoyancy: mostly a value within +-2.0, sometimes anything
	function automatic logic signed [W-1:0] rand_buoy();
		if ($urandom_range(9) < 3)
			return rand_q16();
		return $signed($urandom_range(32'h0002_0000)) * ($urandom_range(5) == 0 ? -1 : 1);
	endfunction

	// One tap item; called and left at a falling edge, valid stays high afterwards
	task automatic drive_tap(input logic fn, input logic [TAP_W-1:0] tp,
			input logic signed [W-1:0] af, ab, bf, bb, b00, b01, b10, b11, vold,
			input logic lst);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid         = 1'b1;
		in_ch.func          = fn;
		in_ch.tap           = tp;
		in_ch.stress_a_fwd  = af;
		in_ch.stress_a_back = ab;
		in_ch.stress_b_fwd  = bf;
		in_ch.stress_b_back = bb;
		in_ch.buoy_00       = b00;
		in_ch.buoy_01       = b01;
		in_ch.buoy_10       = b10;
		in_ch.buoy_11       = b11;
		in_ch.vel_old       = vold;
		in_ch.last_tap      = lst;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Hold off the sender until every expected velocity has come back
	task automatic wait_results();
		in_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Quiet point for coefficient writes: results back, last taps accumulated
	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_coefs(input coef_style_t style);
		logic [W-1:0] v;
		for (int i = 0; i < NUM_REGS; i++) begin
			case (style)
				COEF_DIRECTED: v = DIRECTED_COEFS[i];
				COEF_ZERO:     v = '0;
				COEF_MAX:      v = Q_MAX;
				COEF_MIN:      v = Q_MIN;
				COEF_SMALL:    v = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
				COEF_FULL:     v = $urandom;
				default:       v = rand_q16();
			endcase
			cfg_we    = 1'b1;
			cfg_index = CFG_IDX_W'(i);
			cfg_data  = v;
			@(negedge clk);
		end
		cfg_we = 1'b0;
	endtask

	// A velocity point: well-formed taps in order, or a scrambled sequence
	task automatic send_point(input logic clean);
		int                  n;
		logic                fn;
		logic signed [W-1:0] b00, b01, b10, b11, vold;
		n    = $urandom_range(MAX_TAPS, 1);
		fn   = 1'($urandom_range(1));
		b00  = rand_buoy();
		b01  = rand_buoy();
		b10  = rand_buoy();
		b11  = rand_buoy();
		vold = rand_q16();
		for (int k = 0; k < n; k++) begin
			if (clean)
				drive_tap(fn, TAP_W'(k), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
					b00, b01, b10, b11, vold, k == n - 1);
			else
				drive_tap(1'($urandom_range(1)), TAP_W'($urandom_range(MAX_TAPS - 1)),
					rand_q16(), rand_q16(), rand_q16(), rand_q16(),
					rand_buoy(), rand_buoy(), rand_buoy(), rand_buoy(), rand_q16(),
					$urandom_range(2) == 0);
		end
	endtask

	task automatic run_points(input int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			send_point($urandom_range(4) != 0);
			if ($urandom_range(39) == 0)
				wait_results();
		end
	endtask

	initial begin
		in_ch.valid         = 1'b0;
		in_ch.func          = FUNC_VX;
		in_ch.tap           = '0;
		in_ch.stress_a_fwd  = '0;
		in_ch.stress_a_back = '0;
		in_ch.stress_b_fwd  = '0;
		in_ch.stress_b_back = '0;
		in_ch.buoy_00       = '0;
		in_ch.buoy_01       = '0;
		in_ch.buoy_10       = '0;
		in_ch.buoy_11       = '0;
		in_ch.vel_old       = '0;
		in_ch.last_tap      = 1'b0;
		out_ch.ready        = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed points
		load_coefs(COEF_DIRECTED);
		drive_tap(FUNC_VX, 2'd0, 32'sh3_0000, Q_ONE, Q_ONE, 0, Q_ONE, 0, 0, 0, Q_HALF, 1'b1);
		drive_tap(FUNC_VZ, 2'd0, Q_ONE, Q_HALF, -Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 1'b0);
		drive_tap(FUNC_VZ, 2'd1, 32'sh100, 32'sh80, 32'sh40, -32'sh40, 0, 0, 0, 0, 0, 1'b0);
		drive_tap(FUNC_VZ, 2'd2, -32'sh300, 32'sh10, 32'sh7, 0, 0, 0, 0, 0, 0, 1'b0);
		drive_tap(FUNC_VZ, 2'd3, Q_ONE, 0, 32'sh1234, 0, Q_ONE, 32'sh2_0000, Q_HALF,
			32'sh4000, -Q_ONE, 1'b1);
		// huge products saturating both ways
		drive_tap(FUNC_VX, 2'd1, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 0, 0, 0, Q_MAX, 1'b1);
		drive_tap(FUNC_VX, 2'd2, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 0, 0, 0, Q_MIN, 1'b1);
		// floor of negative products and of the scaled sum
		drive_tap(FUNC_VX, 2'd3, Q_LSB, 0, 0, Q_LSB, 0, 0, 0, 0, 0, 1'b0);
		drive_tap(FUNC_VX, 2'd3, 0, 0, 0, 0, Q_LSB, 0, 0, 0, 32'sh1234, 1'b1);
		// floor of a negative buoyancy mean
		drive_tap(FUNC_VZ, 2'd0, Q_ONE, 0, 0, 0, Q_NEG, Q_NEG, Q_NEG, 0, 0, 1'b1);
		// component changes within a point
		drive_tap(FUNC_VZ, 2'd0, Q_ONE, 0, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 1'b0);
		drive_tap(FUNC_VX, 2'd1, 32'sh40, 0, 0, 32'sh40, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 1'b0);
		drive_tap(FUNC_VZ, 2'd2, 0, 32'sh20, 0, 0, Q_ONE, Q_HALF, Q_ONE, 0, Q_ONE, 1'b1);
		drive_tap(FUNC_VZ, 2'd0, Q_HALF, 0, 0, 0, Q_ONE, Q_MAX, Q_MIN, 0, 0, 1'b0);
		drive_tap(FUNC_VX, 2'd3, 0, 0, Q_MAX, 0, 32'sh2_0000, Q_MAX, Q_MAX, 0, 0, 1'b1);
		// buoyancy extremes for vz, all-ones and all-zero fields
		drive_tap(FUNC_VZ, 2'd0, Q_ONE, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 1'b1);
		drive_tap(FUNC_VZ, 2'd0, Q_ONE, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b1);
		drive_tap(FUNC_VZ, 2'd3, Q_NEG, Q_NEG, Q_NEG, Q_NEG, Q_NEG, Q_NEG, Q_NEG, Q_NEG,
			Q_NEG, 1'b1);
		drive_tap(FUNC_VX, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0, Q_MIN, 1'b1);
		settle();

		// Random points under several coefficient settings
		load_coefs(COEF_SMALL);
		run_points(PHASE_ITEMS);
		settle();
		load_coefs(COEF_FULL);
		calm = 1'b1;
		run_points(PHASE_ITEMS);
		calm = 1'b0;
		settle();
		load_coefs(COEF_MAX);
		run_points(PHASE_ITEMS);
		settle();
		load_coefs(COEF_ZERO);
		run_points(PHASE_ITEMS);
		settle();
		load_coefs(COEF_SMALL);
		run_points(PHASE_ITEMS);
		settle();
		load_coefs(COEF_MIX);
		run_points(PHASE_ITEMS);
		settle();

		// Tap sum driven to a large magnitude, then one negative term and a close
		load_coefs(COEF_MIN);
		drive_tap(FUNC_VX, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
		for (int k = 0; k < BIG_ITEMS; k++)
			drive_tap(FUNC_VX, TAP_W'(k), Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0, 0, 0, 1'b0);
		drive_tap(FUNC_VX, 2'd0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, 0, 0, 1'b0);
		drive_tap(FUNC_VX, 2'd1, 0, 0, 0, 0, Q_ONE, 0, 0, 0, 0, 1'b1);
		settle();
		load_coefs(COEF_SMALL);
		run_points(PHASE_ITEMS / 3);

		settle();
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Run limit, far beyond the slowest correct run
	initial begin
		#40_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
